// ===== design/poua_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package poua_pkg;

    localparam int unsigned TICK_W  = 48;
    localparam int unsigned MS_W    = 56;
    localparam int unsigned OWNER_W = 32;
    localparam int unsigned RATE_W  = 14;

    localparam logic [RATE_W-1:0]  RATE_DEFAULT = 14'd100;
    localparam logic [OWNER_W-1:0] NO_OWNER     = 32'hFFFF_FFFF;
    localparam logic [MS_W-1:0]    MS_MAX       = {MS_W{1'b1}};
    localparam logic [9:0]         MS_PER_S     = 10'd1000;

    typedef enum logic [1:0] {
        CMD_BASE   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_BASE    = 3'd0,
        ST_CHARGED = 3'd1,
        ST_NOTHING = 3'd2,
        ST_FULL    = 3'd3,
        ST_BADTASK = 3'd4,
        ST_READOK  = 3'd5,
        ST_READMT  = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        task_id;
        logic [OWNER_W-1:0] owner_id;
        logic [TICK_W-1:0]  tick_total;
        logic [11:0]        entry_index;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic [11:0]        owner_slot;
        logic [OWNER_W-1:0] owner_value;
        logic [MS_W-1:0]    owner_total_ms;
        logic [MS_W-1:0]    charged_ms;
        logic [12:0]        owners_in_use;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TREAD,
        S_TCHECK,
        S_DIV,
        S_DIVWAIT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_ADD,
        S_ORD,
        S_ORD2,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       cap_req;
        logic       task_rd;
        logic       task_wr;
        logic       div_start;
        logic       own_rd;
        logic       srch_first;
        logic       srch_next;
        logic       app_wr;
        logic       add_wr;
        logic       out_load;
        logic [2:0] status;
        logic       use_slot;
        logic       read_mode;
    } t_cmdbus;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       bad;
        logic       known;
        logic       delta_pos;
        logic       div_done;
        logic       ms_zero;
        logic       match;
        logic       srch_end;
        logic       full;
        logic       rd_ok;
        logic       clearing;
    } t_stat;

endpackage
`default_nettype wire

// ===== design/per_owner_usage_accounting.sv =====
// Per-owner usage accounting.
// Request channel: i_valid / o_stall carry one report (baseline, sample or
// owner table read); the result channel o_valid / i_stall returns exactly one
// result per request. One request is in work at a time: o_stall stays high
// from acceptance until the result is loaded into the output register.
// A read goes through the task read, the check and the owner read states
// S_ORD and S_ORD2; a baseline, a bad task, an unused command or a sample
// with no growth goes from the check straight to the result. A charging
// sample runs a 58-step bit-serial divide and then scans the owner table
// entry by entry; the worst case, with 4096 entries in use, is set by the
// linear search over the single-port owner memory.
// After reset the task store is swept clear, one entry a cycle; the block
// keeps o_stall high meanwhile. tick_rate resets to 100 and is written over
// the APB port, register 0 at address 0.
// When the receiver stalls, the result holds in the output register; the
// next request may still be taken, but its result waits until the held one
// has left.
`timescale 1ns / 1ps
`default_nettype none
module per_owner_usage_accounting #(
    parameter int unsigned TASK_SLOTS  = 65536,
    parameter int unsigned OWNER_SLOTS = 4096
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire poua_pkg::t_req  i_req,
    output logic                 o_valid,
    input  wire                  i_stall,
    output poua_pkg::t_rsp       o_rsp,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [1:0]            paddr,
    input  wire [31:0]           pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import poua_pkg::*;

    logic [RATE_W-1:0] r_rate;
    t_cmdbus           w_cb;
    t_stat             w_st;
    logic              w_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_DEFAULT;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_rate <= pwdata[RATE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {18'd0, r_rate} : 32'd0;

    poua_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (w_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_st    (w_st),
        .o_cb    (w_cb)
    );

    poua_dp #(
        .TASK_SLOTS  (TASK_SLOTS),
        .OWNER_SLOTS (OWNER_SLOTS)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .i_rate (r_rate),
        .i_cb   (w_cb),
        .o_st   (w_st),
        .o_rsp  (o_rsp)
    );

    assign o_stall = w_stall;
endmodule
`default_nettype wire

// ===== design/poua_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module poua_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  wire                  i_stall,
    input  wire poua_pkg::t_stat i_st,
    output poua_pkg::t_cmdbus    o_cb
);
    import poua_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;
    // hold requests off while busy or while the task store sweep runs
    assign o_stall = (r_state != S_IDLE) || i_st.clearing;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && i_stall;
        o_cb     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !i_st.clearing) begin
                    o_cb.cap_req = 1'b1;
                    n_state      = S_TREAD;
                end
            end
            S_TREAD: begin
                o_cb.task_rd = 1'b1;
                n_state      = S_TCHECK;
            end
            S_TCHECK: begin
                n_state = S_DONE;
                if (i_st.cmd == CMD_READ) begin
                    o_cb.own_rd    = 1'b1;
                    o_cb.read_mode = 1'b1;
                    n_state        = S_ORD;
                end else if (i_st.cmd == CMD_NONE) begin
                    o_cb.status = ST_NOTHING;
                end else if (i_st.bad) begin
                    o_cb.status = ST_BADTASK;
                end else if (!i_st.known) begin
                    o_cb.task_wr = 1'b1;
                    if (i_st.cmd == CMD_BASE) begin
                        o_cb.status = ST_BASE;
                    end else begin
                        o_cb.div_start = 1'b1;
                        n_state        = S_DIVWAIT;
                    end
                end else if (i_st.cmd == CMD_BASE) begin
                    o_cb.status = ST_NOTHING;
                end else begin
                    o_cb.task_wr = 1'b1;
                    if (i_st.delta_pos) begin
                        o_cb.div_start = 1'b1;
                        n_state        = S_DIV;
                    end else begin
                        o_cb.status = ST_NOTHING;
                    end
                end
            end
            // S_DIV: known task path; S_DIVWAIT: new task path (zero ms skips)
            S_DIV, S_DIVWAIT: begin
                if (i_st.div_done) begin
                    if (r_state == S_DIVWAIT && i_st.ms_zero) begin
                        o_cb.status = ST_NOTHING;
                        n_state     = S_DONE;
                    end else begin
                        o_cb.srch_first = 1'b1;
                        n_state         = S_SRCH_RD;
                    end
                end
            end
            S_SRCH_RD: begin
                if (i_st.srch_end) begin
                    if (i_st.full) begin
                        o_cb.status = ST_FULL;
                        n_state     = S_DONE;
                    end else begin
                        o_cb.app_wr = 1'b1;
                        n_state     = S_ADD;
                    end
                end else begin
                    o_cb.own_rd = 1'b1;
                    n_state     = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (i_st.match) begin
                    n_state = S_ADD;
                end else begin
                    o_cb.srch_next = 1'b1;
                    n_state        = S_SRCH_RD;
                end
            end
            S_ADD: begin
                o_cb.add_wr   = 1'b1;
                o_cb.status   = ST_CHARGED;
                o_cb.use_slot = 1'b1;
                n_state       = S_DONE;
            end
            S_ORD: begin
                o_cb.read_mode = 1'b1;
                n_state        = S_ORD2;
            end
            S_ORD2: begin
                o_cb.read_mode = 1'b1;
                o_cb.use_slot  = i_st.rd_ok;
                o_cb.status    = i_st.rd_ok ? ST_READOK : ST_READMT;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    o_cb.out_load = 1'b1;
                    n_ovalid      = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // status/slot are latched in datapath when not DONE
        if (r_state == S_DONE) begin
            o_cb.status = 3'd0;
        end
    end
endmodule
`default_nettype wire

// ===== design/poua_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module poua_div (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    input  wire [poua_pkg::TICK_W+9:0]         i_num,
    input  wire [poua_pkg::RATE_W-1:0]         i_den,
    output logic                               o_done,
    output logic [poua_pkg::TICK_W+9:0]        o_quo
);
    import poua_pkg::*;

    localparam int unsigned NW = TICK_W + 10;
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0]   r_q, n_q;
    logic [RATE_W:0] r_rem, n_rem;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_busy, n_busy, r_done, n_done;
    logic [RATE_W+1:0] w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    // restoring division, one quotient bit per cycle
    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh   = {r_rem, r_q[NW-1]};
        if (i_start) begin
            n_q    = i_num;
            n_rem  = '0;
            n_cnt  = CW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {2'b00, i_den}) begin
                n_rem = (RATE_W+1)'(w_sh - {2'b00, i_den});
                n_q   = {r_q[NW-2:0], 1'b1};
            end else begin
                n_rem = w_sh[RATE_W:0];
                n_q   = {r_q[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule
`default_nettype wire

// ===== design/poua_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module poua_dp #(
    parameter int unsigned TASK_SLOTS  = 65536,
    parameter int unsigned OWNER_SLOTS = 4096
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire poua_pkg::t_req     i_req,
    input  wire [poua_pkg::RATE_W-1:0] i_rate,
    input  wire poua_pkg::t_cmdbus  i_cb,
    output poua_pkg::t_stat         o_st,
    output poua_pkg::t_rsp          o_rsp
);
    import poua_pkg::*;

    localparam int unsigned TAW = (TASK_SLOTS > 2) ? $clog2(TASK_SLOTS) : 1;
    localparam int unsigned OAW = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
    localparam int unsigned OCW = $clog2(OWNER_SLOTS + 1);
    localparam int unsigned TW  = 1 + OWNER_W + TICK_W;
    localparam int unsigned NW  = TICK_W + 10;

    // task store: valid flag kept in each word, cleared by a sweep after reset
    logic [TW-1:0]      r_tmem [TASK_SLOTS];
    logic [OWNER_W-1:0] r_oid  [OWNER_SLOTS];
    logic [MS_W-1:0]    r_oms  [OWNER_SLOTS];

    t_req               r_req;
    logic [TW-1:0]      r_trd;
    logic [OWNER_W-1:0] r_oid_rd;
    logic [MS_W-1:0]    r_oms_rd;
    logic [OCW-1:0]     r_count;
    logic [OCW-1:0]     r_idx;
    logic [MS_W-1:0]    r_ms;
    logic [2:0]         r_status;
    logic [11:0]        r_slot;
    logic [OWNER_W-1:0] r_val;
    logic [MS_W-1:0]    r_tot, r_chg;
    t_rsp               r_rsp;
    logic [TAW:0]       r_clr;

    logic              w_clearing;
    logic [TICK_W-1:0] w_last, w_dticks;
    logic [NW-1:0]     w_num, w_quo;
    logic              w_div_done;
    logic [RATE_W-1:0] w_rate;
    logic [MS_W:0]     w_sum;
    logic [MS_W-1:0]   w_new;
    logic [TAW-1:0]    w_taddr;
    logic [OAW-1:0]    w_oaddr;
    logic              w_known;

    assign w_clearing = !r_clr[TAW];
    assign w_taddr    = TAW'(r_req.task_id);
    assign w_last     = r_trd[TICK_W-1:0];
    assign w_known    = r_trd[TW-1] && (r_trd[TICK_W +: OWNER_W] == r_req.owner_id);
    assign w_dticks   = w_known ? (r_req.tick_total - w_last) : r_req.tick_total;
    assign w_num      = NW'(w_dticks) * NW'(MS_PER_S);
    assign w_rate     = (i_rate == '0) ? RATE_DEFAULT : i_rate;
    assign w_oaddr    = i_cb.read_mode ? OAW'(r_req.entry_index) : r_idx[OAW-1:0];

    poua_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cb.div_start),
        .i_num   (w_num),
        .i_den   (w_rate),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            if (w_clearing) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cb.app_wr) begin
                r_count <= r_count + 1'b1;
            end
        end
        if (w_clearing) begin
            r_tmem[r_clr[TAW-1:0]] <= '0;
        end else if (i_cb.task_wr) begin
            r_tmem[w_taddr] <= {1'b1, r_req.owner_id, r_req.tick_total};
        end
        if (i_cb.task_rd) begin
            r_trd <= r_tmem[w_taddr];
        end
        if (i_cb.cap_req) begin
            r_req <= i_req;
        end
        if (i_cb.own_rd) begin
            r_oid_rd <= r_oid[w_oaddr];
            r_oms_rd <= r_oms[w_oaddr];
        end
        if (i_cb.app_wr) begin
            r_oid[w_oaddr] <= r_req.owner_id;
            r_oms_rd       <= '0;
            r_oid_rd       <= r_req.owner_id;
        end
        if (i_cb.add_wr) begin
            r_oms[w_oaddr] <= w_new;
        end
        if (w_div_done) begin
            r_ms <= (w_quo[NW-1:MS_W] != '0) ? MS_MAX : w_quo[MS_W-1:0];
        end
        if (i_cb.srch_first) begin
            r_idx <= '0;
        end else if (i_cb.srch_next) begin
            r_idx <= r_idx + 1'b1;
        end
        // hold result fields until the output register takes them
        if (i_cb.task_rd) begin
            r_status <= ST_NOTHING;
            r_slot   <= '0;
            r_val    <= '0;
            r_tot    <= '0;
            r_chg    <= '0;
        end else if (i_cb.add_wr || (i_cb.status != '0) ||
                     (i_cb.read_mode && !i_cb.own_rd && i_cb.use_slot == 1'b0 &&
                      i_cb.status != '0)) begin
            r_status <= i_cb.status;
            if (i_cb.use_slot) begin
                r_slot <= i_cb.read_mode ? r_req.entry_index : 12'(r_idx);
                r_val  <= r_oid_rd;
                r_tot  <= i_cb.read_mode ? r_oms_rd : w_new;
                r_chg  <= i_cb.read_mode ? '0 : r_ms;
            end
        end else if (i_cb.status == '0 && (i_cb.task_wr && !i_cb.div_start)) begin
            r_status <= ST_BASE;
        end
        if (i_cb.out_load) begin
            r_rsp.status         <= r_status;
            r_rsp.owner_slot     <= r_slot;
            r_rsp.owner_value    <= r_val;
            r_rsp.owner_total_ms <= r_tot;
            r_rsp.charged_ms     <= r_chg;
            r_rsp.owners_in_use  <= 13'(r_count);
        end
    end

    assign w_sum = {1'b0, r_oms_rd} + {1'b0, r_ms};
    assign w_new = w_sum[MS_W] ? MS_MAX : w_sum[MS_W-1:0];

    always_comb begin
        o_st           = '0;
        o_st.cmd       = r_req.cmd;
        o_st.bad       = (r_req.task_id == '0) ||
                         ({8'd0, r_req.task_id} >= 24'(TASK_SLOTS)) ||
                         (r_req.owner_id == NO_OWNER) || w_clearing;
        o_st.known     = w_known;
        o_st.delta_pos = r_req.tick_total > w_last;
        o_st.div_done  = w_div_done;
        o_st.ms_zero   = (w_quo == '0);
        o_st.match     = (r_oid_rd == r_req.owner_id);
        o_st.srch_end  = (r_idx >= r_count);
        o_st.full      = (r_count >= OCW'(OWNER_SLOTS));
        o_st.rd_ok     = (32'(r_req.entry_index) < 32'(r_count)) &&
                         (32'(r_req.entry_index) < OWNER_SLOTS);
        o_st.clearing  = w_clearing;
    end

    assign o_rsp = r_rsp;
endmodule
`default_nettype wire

// ===== sim/tb_per_owner_usage_accounting.sv =====
`timescale 1ns / 1ps
`default_nettype none

class usage_scoreboard;
    logic [13:0] tick_rate;
    bit          task_known [int unsigned];
    logic [31:0] task_owner [int unsigned];
    logic [47:0] task_ticks [int unsigned];
    int unsigned n_owners;
    logic [31:0] owner_ids  [int unsigned];
    logic [55:0] owner_ms   [int unsigned];
    poua_pkg::t_rsp pending[$];
    int errors;
    int n_checked;
    int n_charged;
    int n_full;

    function new();
        tick_rate = poua_pkg::RATE_DEFAULT;
        n_owners  = 0;
        errors    = 0;
        n_checked = 0;
        n_charged = 0;
        n_full    = 0;
    endfunction

    function logic [55:0] to_ms(logic [47:0] ticks);
        logic [63:0] rate;
        logic [63:0] ms;
        rate = (tick_rate == 0) ? 64'd100 : {50'd0, tick_rate};
        ms = ({16'd0, ticks} * 64'd1000) / rate;
        return (ms > {8'd0, poua_pkg::MS_MAX}) ? poua_pkg::MS_MAX : ms[55:0];
    endfunction

    function poua_pkg::t_rsp blank(logic [2:0] st);
        poua_pkg::t_rsp r;
        r = '0;
        r.status = st;
        r.owners_in_use = n_owners[12:0];
        return r;
    endfunction

    function poua_pkg::t_rsp add_usage(logic [31:0] owner, logic [55:0] ms);
        int unsigned i;
        poua_pkg::t_rsp r;
        for (i = 0; i < n_owners; i++)
            if (owner_ids[i] == owner) break;
        if (i >= n_owners) begin
            if (n_owners >= 4096) begin
                n_full++;
                return blank(poua_pkg::ST_FULL);
            end
            i = n_owners;
            n_owners++;
            owner_ids[i] = owner;
            owner_ms[i] = '0;
        end
        owner_ms[i] = (owner_ms[i] > poua_pkg::MS_MAX - ms) ? poua_pkg::MS_MAX
                                                             : owner_ms[i] + ms;
        r = blank(poua_pkg::ST_CHARGED);
        r.owner_slot = i[11:0];
        r.owner_value = owner_ids[i];
        r.owner_total_ms = owner_ms[i];
        r.charged_ms = ms;
        n_charged++;
        return r;
    endfunction

    function void note_request(poua_pkg::t_req q);
        poua_pkg::t_rsp r;
        int unsigned t;
        logic [47:0] delta;
        logic [55:0] ms;
        t = q.task_id;
        if (q.cmd == poua_pkg::CMD_READ) begin
            if (q.entry_index < n_owners) begin
                r = blank(poua_pkg::ST_READOK);
                r.owner_slot = q.entry_index;
                r.owner_value = owner_ids[q.entry_index];
                r.owner_total_ms = owner_ms[q.entry_index];
            end else begin
                r = blank(poua_pkg::ST_READMT);
            end
        end else if (q.cmd == poua_pkg::CMD_NONE) begin
            r = blank(poua_pkg::ST_NOTHING);
        end else if (t == 0 || q.owner_id == poua_pkg::NO_OWNER) begin
            r = blank(poua_pkg::ST_BADTASK);
        end else if (!task_known.exists(t) || task_owner[t] != q.owner_id) begin
            task_known[t] = 1;
            task_owner[t] = q.owner_id;
            task_ticks[t] = q.tick_total;
            if (q.cmd == poua_pkg::CMD_BASE) begin
                r = blank(poua_pkg::ST_BASE);
            end else begin
                ms = to_ms(q.tick_total);
                r = (ms > 0) ? add_usage(q.owner_id, ms) : blank(poua_pkg::ST_NOTHING);
            end
        end else if (q.cmd == poua_pkg::CMD_BASE) begin
            r = blank(poua_pkg::ST_NOTHING);
        end else begin
            delta = (q.tick_total > task_ticks[t]) ? q.tick_total - task_ticks[t] : '0;
            task_ticks[t] = q.tick_total;
            r = (delta > 0) ? add_usage(q.owner_id, to_ms(delta))
                            : blank(poua_pkg::ST_NOTHING);
        end
        pending.push_back(r);
    endfunction

    function void check_result(poua_pkg::t_rsp got);
        poua_pkg::t_rsp e;
        if (pending.size() == 0) begin
            $error("unexpected result, status %0d", got.status);
            errors++;
            return;
        end
        e = pending.pop_front();
        n_checked++;
        if (got.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status); errors++;
        end
        if (got.owner_slot !== e.owner_slot) begin
            $error("owner_slot: expected %0d, got %0d", e.owner_slot, got.owner_slot);
            errors++;
        end
        if (got.owner_value !== e.owner_value) begin
            $error("owner_value: expected %0h, got %0h", e.owner_value, got.owner_value);
            errors++;
        end
        if (got.owner_total_ms !== e.owner_total_ms) begin
            $error("owner_total_ms: expected %0d, got %0d", e.owner_total_ms,
                   got.owner_total_ms);
            errors++;
        end
        if (got.charged_ms !== e.charged_ms) begin
            $error("charged_ms: expected %0d, got %0d", e.charged_ms, got.charged_ms);
            errors++;
        end
        if (got.owners_in_use !== e.owners_in_use) begin
            $error("owners_in_use: expected %0d, got %0d", e.owners_in_use,
                   got.owners_in_use);
            errors++;
        end
    endfunction
endclass

module tb_per_owner_usage_accounting;
    import poua_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_req        i_req;
    logic        o_valid;
    logic        i_stall;
    t_rsp        o_rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    usage_scoreboard ledger;
    longint cycle_count;
    int     stall_mode;
    logic [31:0] owner_pool [8];
    logic [47:0] tick_now [16];

    per_owner_usage_accounting dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 64'd3_000_000) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // receiver: check results, stall on a shifting pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) ledger.check_result(o_rsp);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    task automatic send(t_req q);
        i_req   <= q;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        ledger.note_request(q);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic gap();
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        while (ledger.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [31:0] v);
        drain();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        ledger.tick_rate = v[13:0];
    endtask

    function automatic t_req mk(t_cmd c, logic [15:0] t, logic [31:0] o,
                                logic [47:0] k, logic [11:0] e);
        t_req q;
        q.cmd = c; q.task_id = t; q.owner_id = o; q.tick_total = k; q.entry_index = e;
        return q;
    endfunction

    function automatic t_req random_req();
        t_req q;
        int   s;
        int   r;
        s = $urandom_range(0, 15);
        r = $urandom_range(0, 99);
        q = mk(CMD_SAMPLE, 16'(s + 1), owner_pool[$urandom_range(0, 7)],
               tick_now[s], 12'($urandom_range(0, 15)));
        if (r < 55) begin
            tick_now[s] = tick_now[s] + $urandom_range(0, 5000);
            q.tick_total = tick_now[s];
        end else if (r < 65) begin
            q.cmd = CMD_BASE;
        end else if (r < 75) begin
            q.cmd = CMD_READ;
            if ($urandom_range(0, 3) == 0) q.entry_index = 12'($urandom);
        end else if (r < 80) begin
            q.cmd = CMD_NONE;
        end else if (r < 85) begin
            q.task_id = 16'($urandom);
            q.owner_id = $urandom;
            q.tick_total = {16'($urandom), $urandom};
            q.cmd = t_cmd'($urandom_range(0, 1));
        end else if (r < 90) begin
            q.owner_id = ($urandom_range(0, 1) == 0) ? NO_OWNER : q.owner_id;
            q.task_id  = ($urandom_range(0, 1) == 0) ? 16'd0 : q.task_id;
        end else begin
            q.tick_total = tick_now[s] - $urandom_range(0, 50);
        end
        return q;
    endfunction

    initial begin
        ledger = new();
        i_rst_n = 0; i_valid = 0; i_req = '0; i_stall = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        stall_mode = 0;
        for (int i = 0; i < 8; i++) owner_pool[i] = 1000 + i * 7;
        owner_pool[7] = 32'hFFFF_FFFE;
        owner_pool[6] = 32'd0;
        for (int i = 0; i < 16; i++) tick_now[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: bad tasks, baseline, charges, clamps, saturation, reads
        send(mk(CMD_SAMPLE, 16'd0, 32'd5, 48'd100, 12'd0));
        send(mk(CMD_BASE, 16'd7, NO_OWNER, 48'd100, 12'd0));
        send(mk(CMD_READ, 16'd0, 32'd0, 48'd0, 12'd0));
        send(mk(CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 12'hFFF));
        send(mk(CMD_BASE, 16'hFFFF, 32'hFFFF_FFFE, 48'd10, 12'd0));
        send(mk(CMD_BASE, 16'hFFFF, 32'hFFFF_FFFE, 48'd20, 12'd0));
        send(mk(CMD_SAMPLE, 16'hFFFF, 32'hFFFF_FFFE, 48'd250, 12'd0));
        send(mk(CMD_SAMPLE, 16'hFFFF, 32'hFFFF_FFFE, 48'd100, 12'd0));
        send(mk(CMD_SAMPLE, 16'hFFFF, 32'hFFFF_FFFE, 48'd100, 12'd0));
        send(mk(CMD_SAMPLE, 16'd1, 32'd0, 48'd0, 12'd0));
        send(mk(CMD_SAMPLE, 16'd2, 32'd9, 48'hFFFF_FFFF_FFFF, 12'd0));
        send(mk(CMD_SAMPLE, 16'd2, 32'd10, 48'hFFFF_FFFF_FFFF, 12'd0));
        send(mk(CMD_READ, 16'd0, 32'd0, 48'd0, 12'd1));
        send(mk(CMD_READ, 16'd0, 32'd0, 48'd0, 12'hFFF));
        write_rate(32'd10000);
        send(mk(CMD_BASE, 16'd3, 32'd9, 48'd0, 12'd0));
        send(mk(CMD_SAMPLE, 16'd3, 32'd9, 48'd5, 12'd0));
        send(mk(CMD_SAMPLE, 16'd3, 32'd9, 48'hFFFF_FFFF_FFFF, 12'd0));
        send(mk(CMD_SAMPLE, 16'd3, 32'd9, 48'hFFFF_FFFF_FFFF, 12'd0));
        write_rate(32'd0);
        send(mk(CMD_SAMPLE, 16'd4, 32'd11, 48'd300, 12'd2));
        write_rate(32'd1);
        send(mk(CMD_SAMPLE, 16'd4, 32'd11, 48'd301, 12'd0));
        send(mk(CMD_READ, 16'd0, 32'd0, 48'd0, 12'd0));

        for (int ph = 0; ph < 4; ph++) begin
            stall_mode = ph % 3;
            write_rate(32'($urandom_range(1, 16383)));
            for (int n = 0; n < 36; n++) begin
                send(random_req());
                gap();
                if (n == 18 && ph == 1) drain();
            end
        end
        write_rate(32'd100);

        drain();
        $display("covered %0d results, %0d charges, %0d owner entries, %0d full",
                 ledger.n_checked, ledger.n_charged, ledger.n_owners, ledger.n_full);
        $display("rates 0, 1, 10000 and random; reads, bad tasks, clamps, saturation");
        if (ledger.errors == 0 && ledger.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
